// ===== hdl/swac_pkg.sv =====
package swac_pkg;

  // Operand selection for the shared bit-serial multiplier.
  typedef enum logic [3:0] {
    OP_XX  = 4'd0,
    OP_OXX = 4'd1,
    OP_YY  = 4'd2,
    OP_OYY = 4'd3,
    OP_XY  = 4'd4,
    OP_OXY = 4'd5,
    OP_SXX = 4'd6,
    OP_SYY = 4'd7,
    OP_SXY = 4'd8,
    OP_NXX = 4'd9,
    OP_NYY = 4'd10,
    OP_NXY = 4'd11,
    OP_AB  = 4'd12,
    OP_CC  = 4'd13
  } op_t;

  typedef struct packed {
    logic start;
  } mul_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

  // Search covers result bits 15 down to 0; bit 15 alone means 1.0.
  localparam int unsigned RES_BITS = 16;
  localparam int unsigned FRAC_SHIFT = 30;

endpackage

// ===== hdl/sliding_window_abs_correlation.sv =====
// Sliding-window absolute correlation.
// Input channel: in_valid / in_stall with in_x_sample, in_y_sample (signed
// Q1.15). Each accepted beat pushes the pair into a window of the last WINDOW
// pairs and yields one result beat on out_valid / out_stall:
// out_corr_magnitude = |cov| / sqrt(var_x * var_y) as unsigned Q1.15
// (truncated, 32768 = 1.0), out_zero_covariance set when cov is exactly 0.
// One item is processed at a time. The run time is set by the shared
// bit-serial multiplier (one multiplier bit per cycle), which forms 12
// products per item, or 14 when cov is nonzero, and by the result search,
// which settles one result bit per S_SA/S_SB pass.
// in_stall is high from acceptance until the result is handed to the output
// register, so a new beat may enter while the previous result still waits.
// Reset (rst_n low, synchronous) empties the window: it reads as all-zero
// pairs until every slot has been written once (tracked by a wrap flag, no
// clearing pass). A stalled result holds in the output register; a finished
// item waits in the done state until that register frees up.
module sliding_window_abs_correlation #(
  parameter int WINDOW      = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_x_sample,
  input  logic signed [SAMPLE_BITS-1:0] in_y_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [15:0]                   out_corr_magnitude,
  output logic                          out_zero_covariance
);
  import swac_pkg::*;

  localparam int SW   = SAMPLE_BITS;
  localparam int LW   = $clog2(WINDOW);
  localparam int AW   = $clog2(WINDOW);
  localparam int SUMW = SW + LW;          // signed running sum
  localparam int Q2W  = 2*SW + LW;        // signed second-order sums
  localparam int MW   = 2*SW + 2*LW;      // magnitude of A, B, C
  localparam int OW   = MW + 1;           // signed operand width
  localparam int PW   = 2*MW;             // product width
  localparam int CMPW = 2*MW + 34;        // search arithmetic width

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_RD    = 8'b0000_0010,
    S_MGO   = 8'b0000_0100,
    S_MWAIT = 8'b0000_1000,
    S_ABS   = 8'b0001_0000,
    S_SA    = 8'b0010_0000,
    S_SB    = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t state_r;
  op_t    op_r;

  // window ring
  logic [AW-1:0]   wp_r;
  logic            wrapped_r;
  logic [2*SW-1:0] ram_rdata;
  logic            ram_we;

  // current and departing pair
  logic signed [SW-1:0] x_r, y_r;
  logic signed [SW-1:0] ox_r, oy_r;
  logic signed [SW-1:0] ox_v, oy_v;

  // running sums and correlation terms
  logic signed [SUMW-1:0] sx_r, sy_r;
  logic signed [Q2W-1:0]  sxx_r, syy_r, sxy_r;
  logic signed [MW:0]     a_r, b_r, c_r;
  logic [PW-1:0]          ab_r, cc_r;

  // result search
  logic [CMPW-1:0] p_r, t1_r, t2_r, cand_r, t1_sum, rhs;
  logic [3:0]      bit_r;
  logic [15:0]     res_r;
  logic            zc_r;
  logic            accept_bit;

  // output register
  logic        out_valid_r;
  logic [15:0] out_mag_r;
  logic        out_zc_r;

  // multiplier hookup
  mul_ctl_t        mul_ctl;
  mul_stat_t       mul_stat;
  logic [PW-1:0]   mul_p;
  logic signed [MW:0] opa, opb;
  logic [MW-1:0]   amag, bmag;
  logic            prod_neg;
  logic signed [PW:0] prod_s;

  logic in_fire;
  assign in_fire  = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);

  swac_ram #(
    .WIDTH (2*SW),
    .DEPTH (WINDOW)
  ) u_win (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata ({y_r, x_r}),
    .raddr (wp_r),
    .rdata (ram_rdata)
  );

  // slots not yet written since reset read as zeros (wrap flag clear)
  assign ox_v   = wrapped_r ? ram_rdata[SW-1:0]    : '0;
  assign oy_v   = wrapped_r ? ram_rdata[2*SW-1:SW] : '0;
  assign ram_we = (state_r == S_RD);

  always_comb begin
    opa = '0;
    opb = '0;
    case (op_r)
      OP_XX:  begin opa = OW'(x_r);   opb = OW'(x_r);  end
      OP_OXX: begin opa = OW'(ox_r);  opb = OW'(ox_r); end
      OP_YY:  begin opa = OW'(y_r);   opb = OW'(y_r);  end
      OP_OYY: begin opa = OW'(oy_r);  opb = OW'(oy_r); end
      OP_XY:  begin opa = OW'(x_r);   opb = OW'(y_r);  end
      OP_OXY: begin opa = OW'(ox_r);  opb = OW'(oy_r); end
      OP_SXX: begin opa = OW'(sx_r);  opb = OW'(sx_r); end
      OP_SYY: begin opa = OW'(sy_r);  opb = OW'(sy_r); end
      OP_SXY: begin opa = OW'(sx_r);  opb = OW'(sy_r); end
      OP_NXX: begin opa = OW'(sxx_r); opb = OW'(WINDOW); end
      OP_NYY: begin opa = OW'(syy_r); opb = OW'(WINDOW); end
      OP_NXY: begin opa = OW'(sxy_r); opb = OW'(WINDOW); end
      OP_AB:  begin opa = a_r;        opb = b_r;       end
      OP_CC:  begin opa = c_r;        opb = c_r;       end
      default: begin opa = '0;        opb = '0;        end
    endcase
  end

  assign amag     = opa[MW] ? MW'(-opa) : opa[MW-1:0];
  assign bmag     = opb[MW] ? MW'(-opb) : opb[MW-1:0];
  assign prod_neg = opa[MW] ^ opb[MW];
  assign prod_s   = prod_neg ? -$signed({1'b0, mul_p}) : $signed({1'b0, mul_p});
  assign mul_ctl.start = (state_r == S_MGO);

  swac_mul #(
    .W (MW)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mul_ctl),
    .a     (amag),
    .b     (bmag),
    .stat  (mul_stat),
    .p     (mul_p)
  );

  // r^2*AB tracked incrementally: P = r^2*AB, T1 = (r*AB) << (bit+1),
  // T2 = AB << 2*bit; candidate (r | 2^bit)^2*AB = P + T1 + T2.
  assign rhs        = CMPW'({cc_r, FRAC_SHIFT'(0)});
  assign accept_bit = (cand_r <= rhs);
  assign t1_sum     = accept_bit ? (t1_r + (t2_r << 1)) : t1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      wrapped_r   <= 1'b0;
      sx_r        <= '0;
      sy_r        <= '0;
      sxx_r       <= '0;
      syy_r       <= '0;
      sxy_r       <= '0;
      out_valid_r <= 1'b0;
      op_r        <= OP_XX;
    end else begin
      // the done state reloads the output register itself
      if (out_valid_r && !out_stall && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            x_r     <= in_x_sample;
            y_r     <= in_y_sample;
            state_r <= S_RD;
          end
        end
        S_RD: begin
          ox_r <= ox_v;
          oy_r <= oy_v;
          sx_r <= sx_r + SUMW'(x_r) - SUMW'(ox_v);
          sy_r <= sy_r + SUMW'(y_r) - SUMW'(oy_v);
          if (wp_r == AW'(WINDOW - 1)) begin
            wp_r      <= '0;
            wrapped_r <= 1'b1;
          end else begin
            wp_r <= wp_r + 1'b1;
          end
          op_r    <= OP_XX;
          state_r <= S_MGO;
        end
        S_MGO: begin
          state_r <= S_MWAIT;
        end
        S_MWAIT: begin
          if (mul_stat.done) begin
            case (op_r)
              OP_XX:  sxx_r <= sxx_r + Q2W'(prod_s);
              OP_OXX: sxx_r <= sxx_r - Q2W'(prod_s);
              OP_YY:  syy_r <= syy_r + Q2W'(prod_s);
              OP_OYY: syy_r <= syy_r - Q2W'(prod_s);
              OP_XY:  sxy_r <= sxy_r + Q2W'(prod_s);
              OP_OXY: sxy_r <= sxy_r - Q2W'(prod_s);
              OP_SXX: a_r <= -OW'(prod_s);
              OP_SYY: b_r <= -OW'(prod_s);
              OP_SXY: c_r <= -OW'(prod_s);
              OP_NXX: a_r <= a_r + OW'(prod_s);
              OP_NYY: b_r <= b_r + OW'(prod_s);
              OP_NXY: c_r <= c_r + OW'(prod_s);
              OP_AB:  ab_r <= mul_p;
              OP_CC:  cc_r <= mul_p;
              default: ;
            endcase
            if (op_r == OP_NXY) begin
              state_r <= S_ABS;
            end else if (op_r == OP_CC) begin
              p_r     <= '0;
              t1_r    <= '0;
              t2_r    <= CMPW'(ab_r) << FRAC_SHIFT;
              bit_r   <= 4'(RES_BITS - 1);
              res_r   <= '0;
              state_r <= S_SA;
            end else begin
              op_r    <= op_t'(op_r + 4'd1);
              state_r <= S_MGO;
            end
          end
        end
        S_ABS: begin
          if (c_r == '0) begin
            zc_r    <= 1'b1;
            res_r   <= '0;
            state_r <= S_DONE;
          end else begin
            zc_r    <= 1'b0;
            c_r     <= c_r[MW] ? -c_r : c_r;
            op_r    <= OP_AB;
            state_r <= S_MGO;
          end
        end
        S_SA: begin
          cand_r  <= p_r + t1_r + t2_r;
          state_r <= S_SB;
        end
        S_SB: begin
          if (accept_bit) begin
            p_r          <= cand_r;
            res_r[bit_r] <= 1'b1;
          end
          // full scale taken: no lower bits may follow
          if ((accept_bit && bit_r == 4'(RES_BITS - 1)) || bit_r == '0) begin
            state_r <= S_DONE;
          end else begin
            t1_r    <= t1_sum >> 1;
            t2_r    <= t2_r >> 2;
            bit_r   <= bit_r - 1'b1;
            state_r <= S_SA;
          end
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_mag_r   <= res_r;
            out_zc_r    <= zc_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_corr_magnitude  = out_mag_r;
  assign out_zero_covariance = out_zc_r;

`ifndef SYNTHESIS
  a_mul_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MGO) |-> !mul_stat.busy)
    else $error("multiplier started while busy");

  a_zero_cov_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_zero_covariance) |-> (out_corr_magnitude == 16'd0))
    else $error("zero covariance with nonzero magnitude");

  a_full_scale: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_corr_magnitude <= 16'd32768))
    else $error("magnitude above 1.0");

  a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_RD))
    else $error("accepted beat did not start window read");
`endif

endmodule

// ===== hdl/swac_ram.sv =====
module swac_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/swac_mul.sv =====
module swac_mul #(
  parameter int W = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  swac_pkg::mul_ctl_t   ctl,
  input  logic [W-1:0]         a,
  input  logic [W-1:0]         b,
  output swac_pkg::mul_stat_t  stat,
  output logic [2*W-1:0]       p
);
  import swac_pkg::*;

  // Shift-add: one multiplier bit per cycle, stops once the rest is zero.
  logic           busy_r;
  logic [2*W-1:0] a_r;
  logic [W-1:0]   b_r;
  logic [2*W-1:0] acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (ctl.start) begin
      busy_r <= 1'b1;
    end else if (busy_r && b_r == '0) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      a_r   <= (2*W)'(a);
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r && b_r != '0) begin
      if (b_r[0]) begin
        acc_r <= acc_r + a_r;
      end
      a_r <= a_r << 1;
      b_r <= b_r >> 1;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = busy_r && (b_r == '0);
  assign p         = acc_r;

endmodule
